>>> sv/pis_pkg.sv
// Package: shared types, constants and state encodings of the plane inlier scoring block.
package pis_pkg;
	localparam int MAX_POINTS = 524288;
	localparam int CNT_W = 20;
	localparam int CNT_MAX = (1 << CNT_W) - 1;
	localparam int COUNT_CAP_I = (MAX_POINTS < CNT_MAX) ? MAX_POINTS : CNT_MAX;
	localparam logic [CNT_W-1:0] COUNT_CAP = CNT_W'(COUNT_CAP_I);
	localparam int SUM_W = 44;
	localparam logic [23:0] DIST_SAT = 24'hFFFFFF;
	localparam logic [39:0] COST_SAT = 40'hFF_FFFF_FFFF;
	localparam int ADDR_W = 5;

	localparam logic [2:0] REG_COEF_A = 3'd0;
	localparam logic [2:0] REG_COEF_B = 3'd1;
	localparam logic [2:0] REG_COEF_C = 3'd2;
	localparam logic [2:0] REG_COEF_D = 3'd3;
	localparam logic [2:0] REG_NORM = 3'd4;
	localparam logic [2:0] REG_THRESH = 3'd5;

	localparam logic [31:0] NORM_RST = 32'd65536;
	localparam logic [23:0] THRESH_RST = 24'd655;

	typedef struct packed {
		logic signed [23:0] px;
		logic signed [23:0] py;
		logic signed [23:0] pz;
		logic is_last;
	} pt_t;

	typedef struct packed {
		logic inlier;
		logic signed [23:0] out_x;
		logic signed [23:0] out_y;
		logic signed [23:0] out_z;
		logic done_res;
		logic [19:0] inlier_total;
		logic [23:0] mean_distance;
		logic [39:0] hypothesis_cost;
	} res_t;

	typedef struct packed {
		logic hit;
		logic [23:0] pdist;
		pt_t pt;
	} qe_t;

	typedef struct packed {
		logic signed [31:0] a;
		logic signed [31:0] b;
		logic signed [31:0] c;
		logic signed [31:0] d;
		logic [31:0] norm;
		logic [23:0] thresh;
	} cfg_t;

	typedef enum logic [2:0] {F_IDLE, F_MUL, F_SUM, F_CHK, F_DIV, F_PUSH} front_st_t;
	typedef enum logic [2:0] {B_IDLE, B_MCHK, B_MDIV, B_CDIV, B_OUT} back_st_t;
endpackage

>>> sv/pis_ifs.sv
// Interfaces: point channel and result channel.
interface pis_pt_if;
	logic valid;
	logic ready;
	pis_pkg::pt_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface pis_res_if;
	logic valid;
	logic ready;
	pis_pkg::res_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

>>> sv/pis_div.sv
// Restoring divider, one quotient bit per cycle.
module pis_div (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [31:0] hi,
	input logic [39:0] lo,
	input logic [31:0] den,
	input logic [5:0] nbits,
	output logic done,
	output logic [39:0] quo
);
	logic busy_q, done_q;
	logic [5:0] cnt_q;
	logic [31:0] rem_q, den_q;
	logic [39:0] lo_q, quo_q;
	logic [32:0] r, diff;
	logic ge;

	assign r = {rem_q, lo_q[39]};
	assign diff = r - {1'b0, den_q};
	assign ge = r >= {1'b0, den_q};
	assign done = done_q;
	assign quo = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= nbits;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= hi;
			lo_q <= lo;
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[31:0] : r[31:0];
			lo_q <= {lo_q[38:0], 1'b0};
			quo_q <= {quo_q[38:0], ge};
		end
	end
endmodule

>>> sv/pis_front.sv
// Front end: takes a point, computes its plane distance and classifies it.
module pis_front (
	input logic clk,
	input logic arst_n,
	input pis_pkg::cfg_t cfg,
	input logic in_valid,
	output logic in_ready,
	input pis_pkg::pt_t in_pt,
	output logic q_valid,
	input logic q_ready,
	output pis_pkg::qe_t q_data
);
	pis_pkg::front_st_t st_q, st_d;
	pis_pkg::pt_t pt_q;
	logic signed [55:0] pa_s1, pb_s1, pc_s1;
	logic signed [58:0] sum;
	logic [57:0] mag_q;
	logic [23:0] dist_q;
	logic sat;
	logic div_start, div_done;
	logic [39:0] div_quo;

	assign sum = {{3{pa_s1[55]}}, pa_s1} + {{3{pb_s1[55]}}, pb_s1}
		+ {{3{pc_s1[55]}}, pc_s1} + {{11{cfg.d[31]}}, cfg.d, 16'd0};
	assign sat = (cfg.norm == 32'd0) || (mag_q >= {2'b00, cfg.norm, 24'd0});
	assign div_start = (st_q == pis_pkg::F_CHK) && !sat;

	pis_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.hi(mag_q[55:24]), .lo({mag_q[23:0], 16'd0}), .den(cfg.norm),
		.nbits(6'd24), .done(div_done), .quo(div_quo)
	);

	assign q_data.hit = dist_q < cfg.thresh;
	assign q_data.pdist = dist_q;
	assign q_data.pt = pt_q;

	always_comb begin
		st_d = st_q;
		in_ready = 1'b0;
		q_valid = 1'b0;
		case (st_q)
			pis_pkg::F_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) st_d = pis_pkg::F_MUL;
			end
			pis_pkg::F_MUL: st_d = pis_pkg::F_SUM;
			pis_pkg::F_SUM: st_d = pis_pkg::F_CHK;
			pis_pkg::F_CHK: st_d = sat ? pis_pkg::F_PUSH : pis_pkg::F_DIV;
			pis_pkg::F_DIV: if (div_done) st_d = pis_pkg::F_PUSH;
			pis_pkg::F_PUSH: begin
				q_valid = 1'b1;
				if (q_ready) st_d = pis_pkg::F_IDLE;
			end
			default: st_d = pis_pkg::F_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= pis_pkg::F_IDLE;
		else st_q <= st_d;
	end

	always_ff @(posedge clk) begin
		if (st_q == pis_pkg::F_IDLE && in_valid) pt_q <= in_pt;
		if (st_q == pis_pkg::F_MUL) begin
			pa_s1 <= cfg.a * pt_q.px;
			pb_s1 <= cfg.b * pt_q.py;
			pc_s1 <= cfg.c * pt_q.pz;
		end
		if (st_q == pis_pkg::F_SUM) mag_q <= sum[58] ? 58'(-sum) : sum[57:0];
		if (st_q == pis_pkg::F_CHK && sat) dist_q <= pis_pkg::DIST_SAT;
		if (st_q == pis_pkg::F_DIV && div_done) dist_q <= div_quo[23:0];
	end
endmodule

>>> sv/pis_queue.sv
// Two-entry queue between front and back.
module pis_queue (
	input logic clk,
	input logic arst_n,
	input logic wr_valid,
	output logic wr_ready,
	input pis_pkg::qe_t wr_data,
	output logic rd_valid,
	input logic rd_ready,
	output pis_pkg::qe_t rd_data
);
	pis_pkg::qe_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic push, pop;

	assign wr_ready = cnt_q != 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign rd_data = mem_q[rp_q];
	assign push = wr_valid && wr_ready;
	assign pop = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wr_data;
	end
endmodule

>>> sv/pis_back.sv
// Back end: accumulates inliers, builds results and the cloud summary.
module pis_back (
	input logic clk,
	input logic arst_n,
	input logic q_valid,
	output logic q_ready,
	input pis_pkg::qe_t q_data,
	output logic out_valid,
	input logic out_ready,
	output pis_pkg::res_t out_data
);
	pis_pkg::back_st_t st_q, st_d;
	logic ov_q;
	pis_pkg::res_t res_q;
	logic [19:0] cnt_q, tcnt_q, ncnt;
	logic [43:0] sum_q, tsum_q, nsum;
	logic hitc, pop;
	logic div_start, div_done;
	logic [31:0] div_hi;
	logic [39:0] div_lo, div_quo;
	logic [5:0] div_n;
	logic msat;

	assign out_valid = ov_q;
	assign out_data = res_q;
	assign hitc = q_data.hit && (cnt_q < pis_pkg::COUNT_CAP);
	assign ncnt = cnt_q + {19'd0, hitc};
	assign nsum = sum_q + (hitc ? {20'd0, q_data.pdist} : 44'd0);
	assign msat = tsum_q >= {tcnt_q, 24'd0};

	always_comb begin
		st_d = st_q;
		q_ready = 1'b0;
		div_start = 1'b0;
		div_hi = '0;
		div_lo = '0;
		div_n = 6'd40;
		case (st_q)
			pis_pkg::B_IDLE: begin
				q_ready = !ov_q || out_ready;
				if (q_valid && q_ready && q_data.pt.is_last) st_d = pis_pkg::B_MCHK;
			end
			pis_pkg::B_MCHK: begin
				if (tcnt_q == 20'd0) begin
					st_d = pis_pkg::B_OUT;
				end else if (msat) begin
					div_start = 1'b1;
					div_lo = {pis_pkg::DIST_SAT, 16'd0};
					st_d = pis_pkg::B_CDIV;
				end else begin
					div_start = 1'b1;
					div_hi = {12'd0, tsum_q[43:24]};
					div_lo = {tsum_q[23:0], 16'd0};
					div_n = 6'd24;
					st_d = pis_pkg::B_MDIV;
				end
			end
			pis_pkg::B_MDIV: begin
				if (div_done) begin
					div_start = 1'b1;
					div_lo = {div_quo[23:0], 16'd0};
					st_d = pis_pkg::B_CDIV;
				end
			end
			pis_pkg::B_CDIV: if (div_done) st_d = pis_pkg::B_OUT;
			pis_pkg::B_OUT: st_d = pis_pkg::B_IDLE;
			default: st_d = pis_pkg::B_IDLE;
		endcase
	end

	assign pop = q_valid && q_ready;

	pis_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.hi(div_hi), .lo(div_lo), .den({12'd0, tcnt_q}),
		.nbits(div_n), .done(div_done), .quo(div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= pis_pkg::B_IDLE;
			ov_q <= 1'b0;
			cnt_q <= '0;
			sum_q <= '0;
		end else begin
			st_q <= st_d;
			// last point's result is held back until the summary is done
			if (st_q == pis_pkg::B_OUT) ov_q <= 1'b1;
			else if (pop) ov_q <= !q_data.pt.is_last;
			else if (out_ready) ov_q <= 1'b0;
			if (pop) begin
				if (q_data.pt.is_last) begin
					cnt_q <= '0;
					sum_q <= '0;
				end else begin
					cnt_q <= ncnt;
					sum_q <= nsum;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q.inlier <= q_data.hit;
			res_q.out_x <= q_data.hit ? q_data.pt.px : '0;
			res_q.out_y <= q_data.hit ? q_data.pt.py : '0;
			res_q.out_z <= q_data.hit ? q_data.pt.pz : '0;
			res_q.done_res <= q_data.pt.is_last;
			res_q.inlier_total <= '0;
			res_q.mean_distance <= '0;
			res_q.hypothesis_cost <= '0;
			tcnt_q <= ncnt;
			tsum_q <= nsum;
		end
		if (st_q == pis_pkg::B_MCHK) begin
			res_q.inlier_total <= tcnt_q;
			if (tcnt_q == 20'd0) begin
				res_q.mean_distance <= pis_pkg::DIST_SAT;
				res_q.hypothesis_cost <= pis_pkg::COST_SAT;
			end else if (msat) begin
				res_q.mean_distance <= pis_pkg::DIST_SAT;
			end
		end
		if (st_q == pis_pkg::B_MDIV && div_done) res_q.mean_distance <= div_quo[23:0];
		if (st_q == pis_pkg::B_CDIV && div_done) res_q.hypothesis_cost <= div_quo;
	end
endmodule

>>> sv/plane_inlier_scoring_top.sv
// Top level: register file, front end, queue and back end of the plane scorer.
//
//  channel  | dir | handshake      | payload
//  point    | in  | valid/ready    | px, py, pz, is_last
//  result   | out | valid/ready    | inlier, out_x/y/z, done_res, summary
//  apb      | in  | psel/penable   | six plane registers, 32-bit data
//
// In the front end a point passes the multiply, sum and check states, the
// 24-step distance divide, and the push to the queue; a saturated distance
// skips the divide. The front end takes a new point only after a push.
// The last point adds a 24-step mean and a 40-step cost divide, sharing the
// back end's divider; a saturated mean skips the first, no inliers both.
// A two-entry queue lets the front keep working while results stall.
// arst_n clears control state and registers to their reset values.
module plane_inlier_scoring_top (
	input logic clk,
	input logic arst_n,
	pis_pt_if.sink point,
	pis_res_if.source result,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [pis_pkg::ADDR_W-1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	pis_pkg::cfg_t cfg_q;
	logic wr_en;
	logic [2:0] idx;
	logic fq_valid, fq_ready, bq_valid, bq_ready;
	pis_pkg::qe_t fq_data, bq_data;

	assign pready = 1'b1;
	assign idx = paddr[4:2];
	assign wr_en = psel && penable && pwrite;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.a <= '0;
			cfg_q.b <= '0;
			cfg_q.c <= '0;
			cfg_q.d <= '0;
			cfg_q.norm <= pis_pkg::NORM_RST;
			cfg_q.thresh <= pis_pkg::THRESH_RST;
		end else if (wr_en) begin
			case (idx)
				pis_pkg::REG_COEF_A: cfg_q.a <= pwdata;
				pis_pkg::REG_COEF_B: cfg_q.b <= pwdata;
				pis_pkg::REG_COEF_C: cfg_q.c <= pwdata;
				pis_pkg::REG_COEF_D: cfg_q.d <= pwdata;
				pis_pkg::REG_NORM: cfg_q.norm <= pwdata;
				pis_pkg::REG_THRESH: cfg_q.thresh <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	// register reads
	always_comb begin
		case (idx)
			pis_pkg::REG_COEF_A: prdata = cfg_q.a;
			pis_pkg::REG_COEF_B: prdata = cfg_q.b;
			pis_pkg::REG_COEF_C: prdata = cfg_q.c;
			pis_pkg::REG_COEF_D: prdata = cfg_q.d;
			pis_pkg::REG_NORM: prdata = cfg_q.norm;
			pis_pkg::REG_THRESH: prdata = {8'd0, cfg_q.thresh};
			default: prdata = '0;
		endcase
	end

	pis_front u_front (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.in_valid(point.valid), .in_ready(point.ready), .in_pt(point.data),
		.q_valid(fq_valid), .q_ready(fq_ready), .q_data(fq_data)
	);

	pis_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_data),
		.rd_valid(bq_valid), .rd_ready(bq_ready), .rd_data(bq_data)
	);

	pis_back u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(bq_valid), .q_ready(bq_ready), .q_data(bq_data),
		.out_valid(result.valid), .out_ready(result.ready), .out_data(result.data)
	);
endmodule

>>> tb/tb_plane_inlier_scoring_top.sv
// Testbench: plane inlier scoring block checked against a cycle-free scoring predictor.
module tb_plane_inlier_scoring_top;
	timeunit 1ns;
	timeprecision 1ps;
	import pis_pkg::*;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	pis_pt_if point ();
	pis_res_if result ();

	plane_inlier_scoring_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.point(point),
		.result(result),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// predictor copy of the plane registers and the cloud accumulators
	cfg_t plane;
	logic [19:0] cnt_acc;
	logic [43:0] sum_acc;

	pt_t pending_pts[$];
	res_t expected_scores[$];
	int errors;
	int mismatches;
	bit no_idle;	// last phase: drive and accept every cycle
	int src_gap, snk_gap;

	// |a*x+b*y+c*z+d*2^16| / norm, saturated to 24 bits
	function automatic logic [23:0] plane_dist(pt_t p);
		logic signed [63:0] s;
		logic [63:0] mag;
		logic [63:0] q;
		s = 64'(plane.a) * 64'(p.px) + 64'(plane.b) * 64'(p.py)
			+ 64'(plane.c) * 64'(p.pz) + (64'(plane.d) <<< 16);
		mag = (s < 0) ? -s : s;
		if (plane.norm == 0)
			return DIST_SAT;
		q = mag / {32'd0, plane.norm};
		return (q > 64'hFFFFFF) ? DIST_SAT : q[23:0];
	endfunction

	function automatic res_t score_point(pt_t p);
		res_t r;
		logic [23:0] pdist;
		logic [63:0] mean, cost;
		pdist = plane_dist(p);
		r = '0;
		r.inlier = pdist < plane.thresh;
		if (r.inlier) begin
			r.out_x = p.px;
			r.out_y = p.py;
			r.out_z = p.pz;
			if (cnt_acc < COUNT_CAP) begin
				cnt_acc = cnt_acc + 20'd1;
				sum_acc = sum_acc + {20'd0, pdist};
			end
		end
		r.done_res = p.is_last;
		if (p.is_last) begin
			if (cnt_acc == 0) begin
				r.mean_distance = DIST_SAT;
				r.hypothesis_cost = COST_SAT;
			end else begin
				mean = {20'd0, sum_acc} / cnt_acc;
				if (mean > 64'hFFFFFF) mean = 64'hFFFFFF;
				cost = (mean << 16) / cnt_acc;
				if (cost > 64'hFF_FFFF_FFFF) cost = 64'hFF_FFFF_FFFF;
				r.mean_distance = mean[23:0];
				r.hypothesis_cost = cost[39:0];
			end
			r.inlier_total = cnt_acc;
			cnt_acc = '0;
			sum_acc = '0;
		end
		return r;
	endfunction

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// point driver: predicts at acceptance, bursts of idle cycles on its own
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point.valid <= 0;
			point.data <= '0;
			src_gap <= 0;
		end else begin
			if (point.valid && point.ready)
				expected_scores.insert(expected_scores.size(), score_point(point.data));
			if (!point.valid || point.ready) begin
				if (src_gap > 0) begin
					point.valid <= 0;
					src_gap <= src_gap - 1;
				end else if (pending_pts.size() > 0) begin
					point.valid <= 1;
					point.data <= pending_pts.pop_front();
					if (!no_idle && $urandom_range(0, 9) == 0)
						src_gap <= $urandom_range(1, 15);
				end else
					point.valid <= 0;
			end
		end
	end

	// result monitor with random backpressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result.ready <= 0;
			snk_gap <= 0;
		end else begin
			if (result.valid && result.ready) begin
				if (expected_scores.size() == 0) begin
					errors++;
					if (mismatches++ < 10)
						$display("unexpected result %h", result.data);
				end else begin
					res_t e;
					e = expected_scores.pop_front();
					if (e !== result.data) begin
						errors++;
						if (mismatches++ < 10) begin
							$display("mismatch exp: in=%0b xyz=%h/%h/%h dn=%0b n=%0d m=%h c=%h",
								e.inlier, e.out_x, e.out_y, e.out_z, e.done_res,
								e.inlier_total, e.mean_distance, e.hypothesis_cost);
							$display("mismatch act: in=%0b xyz=%h/%h/%h dn=%0b n=%0d m=%h c=%h",
								result.data.inlier, result.data.out_x, result.data.out_y,
								result.data.out_z, result.data.done_res,
								result.data.inlier_total, result.data.mean_distance,
								result.data.hypothesis_cost);
						end
					end
				end
			end
			if (snk_gap > 0) begin
				result.ready <= 0;
				snk_gap <= snk_gap - 1;
			end else begin
				result.ready <= 1;
				if (!no_idle && $urandom_range(0, 9) == 0)
					snk_gap <= $urandom_range(1, 15);
			end
		end
	end

	task automatic apb_write(logic [2:0] idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1; penable <= 0; pwrite <= 1;
		paddr <= ADDR_W'({idx, 2'b00}); pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		case (idx)
			REG_COEF_A: plane.a = val;
			REG_COEF_B: plane.b = val;
			REG_COEF_C: plane.c = val;
			REG_COEF_D: plane.d = val;
			REG_NORM: plane.norm = val;
			REG_THRESH: plane.thresh = val[23:0];
			default: ;
		endcase
	endtask

	task automatic load_plane(logic [31:0] a, logic [31:0] b, logic [31:0] c,
		logic [31:0] d, logic [31:0] n, logic [23:0] t);
		apb_write(REG_COEF_A, a);
		apb_write(REG_COEF_B, b);
		apb_write(REG_COEF_C, c);
		apb_write(REG_COEF_D, d);
		apb_write(REG_NORM, n);
		apb_write(REG_THRESH, {8'd0, t});
	endtask

	// wait for idle: queues drained plus back-end latency margin
	task automatic drain();
		while (pending_pts.size() > 0 || point.valid || expected_scores.size() > 0)
			@(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	function automatic logic [23:0] rnd_coord();
		case ($urandom_range(0, 5))
			0: return 24'h800000;
			1: return 24'h7FFFFF;
			2, 3: return 24'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
			default: return 24'($urandom);
		endcase
	endfunction

	// cloud of n points, near the plane z = z0 (a=b=0, c=1) when flat so many land as inliers
	task automatic add_cloud(int n, bit flat);
		pt_t p;
		for (int i = 0; i < n; i++) begin
			p.px = rnd_coord();
			p.py = rnd_coord();
			p.pz = flat ? 24'($signed($urandom_range(0, 4000)) - 2000) : rnd_coord();
			p.is_last = (i == n - 1);
			pending_pts.insert(pending_pts.size(), p);
		end
	endtask

	task automatic add_pt(logic [23:0] x, logic [23:0] y, logic [23:0] z, bit last);
		pt_t p;
		p.px = x; p.py = y; p.pz = z; p.is_last = last;
		pending_pts.insert(pending_pts.size(), p);
	endtask

	initial begin
		int done_pts;
		errors = 0;
		mismatches = 0;
		no_idle = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		plane = '{a: 0, b: 0, c: 0, d: 0, norm: NORM_RST, thresh: THRESH_RST};
		cnt_acc = '0;
		sum_acc = '0;
		arst_n = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1;

		// reset values: all-zero plane, every point distance 0 -> all inliers
		add_pt(24'h800000, 24'h7FFFFF, 24'h000000, 0);
		add_pt(24'h7FFFFF, 24'h800000, 24'hFFFFFF, 1);
		drain();

		// extreme coefficients: saturated distance, no inliers on last point
		load_plane(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			32'd1, 24'hFFFFFF);
		add_pt(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 0);
		add_pt(24'h800000, 24'h800000, 24'h800000, 1);
		drain();

		// zero norm: never an inlier
		load_plane(32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0, 24'hFFFFFF);
		add_pt(24'h0, 24'h0, 24'h0, 0);
		add_pt(24'h000010, 24'h0, 24'h0, 1);
		drain();

		// max norm, threshold 0 (nothing strictly below), then threshold max
		load_plane(32'h0, 32'h0, 32'h0001_0000, 32'hFFFF_0000, 32'hFFFF_FFFF, 24'h0);
		add_pt(24'h0, 24'h0, 24'h010000, 1);
		drain();
		load_plane(32'h0, 32'h0, 32'h0001_0000, 32'hFFFF_8000, 32'h0001_0000, 24'hFFFFFF);
		add_pt(24'h0, 24'h0, 24'h000000, 0);
		add_pt(24'h0, 24'h0, 24'h008000, 0);
		add_pt(24'h123456, 24'hABCDEF, 24'h7FFFFF, 1);
		drain();

		// random phases: mostly a z-plane, mostly a small threshold, clouds of random size
		for (int ph = 0; ph < 8; ph++) begin
			load_plane($urandom_range(0, 3) == 0 ? $urandom : 32'h0,
				$urandom_range(0, 3) == 0 ? $urandom : 32'h0,
				32'h0001_0000 + $urandom_range(0, 255),
				32'($signed($urandom_range(0, 64)) - 32),
				32'h0001_0000 + $urandom_range(0, 4096),
				$urandom_range(0, 2) == 0 ? 24'($urandom) : 24'($urandom_range(0, 3000)));
			done_pts = 0;
			while (done_pts < 230) begin
				int n;
				n = $urandom_range(1, 30);
				add_cloud(n, $urandom_range(0, 4) != 0);
				done_pts += n;
			end
			if (ph == 7) no_idle = 1;
			drain();
		end

		if (errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#(12ns * 400000);
		$display("FAILED: results differ");
		$finish;
	end
endmodule

>>> sim.f
sv/pis_pkg.sv
sv/pis_ifs.sv
sv/pis_div.sv
sv/pis_front.sv
sv/pis_queue.sv
sv/pis_back.sv
sv/plane_inlier_scoring_top.sv
tb/tb_plane_inlier_scoring_top.sv
